// File: rtl/dot_matrix_band_transposer_unit_assert.svh
// ----------------------------------------------------------------------------
// dot matrix band transposer - assertion macros
// shared property wrappers, clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DOT_MATRIX_BAND_TRANSPOSER_UNIT_ASSERT_SVH
`define DOT_MATRIX_BAND_TRANSPOSER_UNIT_ASSERT_SVH

// same-cycle implication
`define DMBT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DMBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dmbt_pkg.sv
// ----------------------------------------------------------------------------
// dmbt_pkg
// types and constants shared by the band transposer modules
// ----------------------------------------------------------------------------
`default_nettype none

package dmbt_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_RASTER = 2'd0,
    REQ_FF     = 2'd1,
    REQ_PULL   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // register map
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [0:0] REG_ROW_BYTES = 1'b0;

  localparam int unsigned RB_W = 10;
  localparam logic [RB_W-1:0] RB_RESET = 10'd512;

  // band store geometry
  localparam int unsigned NUM_BANKS = 8;
  localparam int unsigned COL_BYTES = 6;
  localparam int unsigned WORD_W = COL_BYTES * 8;

  // sequence positions
  localparam logic [2:0] HEAD_LAST = 3'd4;
  localparam logic [2:0] TAIL_LAST = 3'd3;
  localparam logic [2:0] SLOT_LAST = 3'(COL_BYTES - 1);

  // command stream bytes
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_FF   = 8'h0C;

  typedef struct packed {
    logic clr_step;
    logic rast_issue;
    logic rast_commit;
    logic ff_take;
    logic pull_issue;
    logic pull_commit;
    logic drop;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic emit_idle;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/dmbt_bank.sv
// ----------------------------------------------------------------------------
// dmbt_bank
// one bank of the band store: one column word per address, read-first
// ----------------------------------------------------------------------------
`default_nettype none

module dmbt_bank #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9,
  parameter int unsigned DATA_W = 48
) (
  input  logic              clk_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic              we_i,
  input  logic [DATA_W-1:0] wd_i,
  input  logic              re_i,
  output logic [DATA_W-1:0] rd_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wd_i;
    end
    if (re_i) begin
      rd_q <= mem_q[addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

// File: rtl/dmbt_ctrl.sv
// ----------------------------------------------------------------------------
// dmbt_ctrl
// sequencing of clear pass, raster read-modify-write, form feeds and output pulls
// ----------------------------------------------------------------------------
`default_nettype none

module dmbt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  dmbt_pkg::req_e    req_type_i,
  output logic              req_stall_o,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  input  dmbt_pkg::sts_t    sts_i,
  output dmbt_pkg::cmd_t    cmd_o
);
  import dmbt_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RAST  = 4'b0100,
    ST_PULL  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   res_valid_q, res_valid_d;
  logic   accept;

  always_comb begin
    req_stall_o = (state_q != ST_IDLE) | (res_valid_q & res_stall_i);
    accept      = req_valid_i & ~req_stall_o;
    cmd_o       = '0;
    state_d     = state_q;
    res_valid_d = res_valid_q & res_stall_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_PULL: begin
              cmd_o.pull_issue = 1'b1;
              state_d          = ST_PULL;
            end
            REQ_RASTER: begin
              if (sts_i.emit_idle) begin
                cmd_o.rast_issue = 1'b1;
                state_d          = ST_RAST;
              end else begin
                cmd_o.drop = 1'b1;
              end
            end
            REQ_FF: begin
              if (sts_i.emit_idle) begin
                cmd_o.ff_take = 1'b1;
              end else begin
                cmd_o.drop = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RAST: begin
        cmd_o.rast_commit = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_PULL: begin
        cmd_o.pull_commit = 1'b1;
        res_valid_d       = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;

endmodule

`default_nettype wire

// File: rtl/dmbt_dpath.sv
// ----------------------------------------------------------------------------
// dmbt_dpath
// band store banks, raster and emission counters, result register
// ----------------------------------------------------------------------------
`default_nettype none

module dmbt_dpath #(
  parameter int unsigned MAX_ROW_BYTES = 512,
  parameter int unsigned BAND_ROWS     = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dmbt_pkg::cmd_t            cmd_i,
  output dmbt_pkg::sts_t            sts_o,
  input  logic [7:0]                pixel_byte_i,
  input  logic                      row_end_i,
  input  logic [dmbt_pkg::RB_W-1:0] row_bytes_i,
  output logic [7:0]                out_byte_o,
  output logic                      out_valid_o,
  output logic                      end_of_burst_o,
  output logic                      overrun_o
);
  import dmbt_pkg::*;

  localparam int unsigned POS_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned COL_W  = $clog2(MAX_ROW_BYTES * 8 + 1);
  localparam int unsigned ROW_W  = $clog2(BAND_ROWS);
  localparam int unsigned LIM_W  = (POS_W > RB_W) ? POS_W : RB_W;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_HEAD = 6'b000010,
    PH_DATA = 6'b000100,
    PH_CR   = 6'b001000,
    PH_TAIL = 6'b010000,
    PH_FF   = 6'b100000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [2:0]          idx_q, idx_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [2:0]          slot_q, slot_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    dot_q, dot_d;
  logic                ffp_q, ffp_d;
  logic                ovr_q, ovr_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [7:0]          pix_q;
  logic                last_q;
  logic [WORD_W-1:0]   word_q;
  logic [7:0]          out_byte_q, res_byte;
  logic                out_valid_q, res_valid;
  logic                eob_q, res_eob;
  logic                ovr_out_q;

  logic [WORD_W-1:0]   rd_data [NUM_BANKS];
  logic [WORD_W-1:0]   bank_wd [NUM_BANKS];
  logic [NUM_BANKS-1:0] bank_we;
  logic                bank_re;
  logic [ADDR_W-1:0]   bank_addr;

  logic                data_rd;
  logic                in_range;
  logic                hit;
  logic [2:0]          jmax;
  logic [COL_W-1:0]    dot_cand;
  logic [ROW_W:0]      row_inc;
  logic                band_full;
  logic [5:0]          row6;
  logic [5:0]          bit_pos;
  logic [WORD_W-1:0]   set_mask;
  logic [WORD_W-1:0]   cur_word;
  logic [15:0]         cnt16;

  // raster byte decode
  always_comb begin
    in_range = (LIM_W'(pos_q) < LIM_W'(row_bytes_i))
             && (pos_q < POS_W'(MAX_ROW_BYTES));
    hit  = |pix_q;
    jmax = '0;
    for (int j = 0; j < NUM_BANKS; j++) begin
      if (pix_q[NUM_BANKS-1-j]) begin
        jmax = 3'(j);
      end
    end
    dot_cand  = COL_W'({pos_q, 3'b000}) + COL_W'(jmax) + COL_W'(1);
    row_inc   = {1'b0, row_q} + (ROW_W+1)'(1);
    band_full = row_inc >= (ROW_W+1)'(BAND_ROWS);
    row6      = 6'(row_q);
    bit_pos   = {row6[5:3], ~row6[2:0]};
    set_mask  = WORD_W'(1) << bit_pos;
  end

  assign data_rd  = cmd_i.pull_issue && (phase_q == PH_DATA) && (slot_q == 3'd0);
  assign cur_word = (slot_q == 3'd0) ? rd_data[col_q[2:0]] : word_q;
  assign cnt16    = 16'(dot_q);

  // bank port control
  always_comb begin
    bank_addr = pos_q[ADDR_W-1:0];
    if (cmd_i.clr_step) begin
      bank_addr = clr_q;
    end else if (data_rd) begin
      bank_addr = col_q[ADDR_W+2:3];
    end
    bank_re = cmd_i.rast_issue | data_rd;
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_we[b] = cmd_i.clr_step
                 | (cmd_i.rast_commit & in_range & pix_q[NUM_BANKS-1-b])
                 | (data_rd & (col_q[2:0] == 3'(b)));
      bank_wd[b] = cmd_i.rast_commit ? (rd_data[b] | set_mask) : '0;
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    dmbt_bank #(
      .DEPTH  (MAX_ROW_BYTES),
      .ADDR_W (ADDR_W),
      .DATA_W (WORD_W)
    ) u_bank (
      .clk_i  (clk_i),
      .addr_i (bank_addr),
      .we_i   (bank_we[b]),
      .wd_i   (bank_wd[b]),
      .re_i   (bank_re),
      .rd_o   (rd_data[b])
    );
  end

  // counters and emission sequence
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    col_d     = col_q;
    slot_d    = slot_q;
    pos_d     = pos_q;
    row_d     = row_q;
    dot_d     = dot_q;
    ffp_d     = ffp_q;
    ovr_d     = ovr_q;
    clr_d     = clr_q;
    res_byte  = '0;
    res_valid = 1'b1;
    res_eob   = 1'b0;

    if (cmd_i.clr_step) begin
      clr_d = clr_q + ADDR_W'(1);
    end
    if (cmd_i.drop) begin
      ovr_d = 1'b1;
    end

    if (cmd_i.ff_take) begin
      ffp_d = 1'b1;
      idx_d = '0;
      if ((row_q != '0) || (pos_q != '0)) begin
        col_d   = '0;
        slot_d  = '0;
        row_d   = '0;
        pos_d   = '0;
        phase_d = (dot_q != '0) ? PH_HEAD : PH_TAIL;
      end else begin
        phase_d = PH_FF;
      end
    end

    if (cmd_i.rast_commit) begin
      if (in_range) begin
        pos_d = pos_q + POS_W'(1);
        if (hit && (dot_cand > dot_q)) begin
          dot_d = dot_cand;
        end
      end
      if (last_q) begin
        pos_d = '0;
        if (band_full) begin
          row_d   = '0;
          ffp_d   = 1'b0;
          idx_d   = '0;
          col_d   = '0;
          slot_d  = '0;
          phase_d = (dot_d != '0) ? PH_HEAD : PH_TAIL;
        end else begin
          row_d = row_inc[ROW_W-1:0];
        end
      end
    end

    if (cmd_i.pull_commit) begin
      case (phase_q)
        PH_HEAD: begin
          case (idx_q)
            3'd0:    res_byte = CH_ESC;
            3'd1:    res_byte = CH_STAR;
            3'd2:    res_byte = CH_H;
            3'd3:    res_byte = cnt16[7:0];
            default: res_byte = cnt16[15:8];
          endcase
          if (idx_q == HEAD_LAST) begin
            idx_d   = '0;
            phase_d = PH_DATA;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        PH_DATA: begin
          res_byte = cur_word[{slot_q, 3'b000} +: 8];
          if (slot_q == SLOT_LAST) begin
            slot_d = '0;
            if ((col_q + COL_W'(1)) == dot_q) begin
              col_d   = '0;
              phase_d = PH_CR;
            end else begin
              col_d = col_q + COL_W'(1);
            end
          end else begin
            slot_d = slot_q + 3'd1;
          end
        end
        PH_CR: begin
          res_byte = CH_CR;
          idx_d    = '0;
          phase_d  = PH_TAIL;
        end
        PH_TAIL: begin
          case (idx_q)
            3'd0:    res_byte = CH_ESC;
            3'd1:    res_byte = CH_PLUS;
            3'd2:    res_byte = CH_ZERO;
            default: res_byte = CH_LF;
          endcase
          if (idx_q == TAIL_LAST) begin
            idx_d = '0;
            dot_d = '0;
            if (ffp_q) begin
              phase_d = PH_FF;
            end else begin
              phase_d = PH_IDLE;
              res_eob = 1'b1;
            end
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        PH_FF: begin
          res_byte = CH_FF;
          res_eob  = 1'b1;
          ffp_d    = 1'b0;
          idx_d    = '0;
          phase_d  = PH_IDLE;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      col_q   <= '0;
      slot_q  <= '0;
      pos_q   <= '0;
      row_q   <= '0;
      dot_q   <= '0;
      ffp_q   <= 1'b0;
      ovr_q   <= 1'b0;
      clr_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      slot_q  <= slot_d;
      pos_q   <= pos_d;
      row_q   <= row_d;
      dot_q   <= dot_d;
      ffp_q   <= ffp_d;
      ovr_q   <= ovr_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rast_issue) begin
      pix_q  <= pixel_byte_i;
      last_q <= row_end_i;
    end
    if (cmd_i.pull_commit && (phase_q == PH_DATA) && (slot_q == 3'd0)) begin
      word_q <= cur_word;
    end
    if (cmd_i.pull_commit) begin
      out_byte_q  <= res_byte;
      out_valid_q <= res_valid;
      eob_q       <= res_eob;
      ovr_out_q   <= ovr_q;
    end
  end

  assign sts_o.clr_done  = (clr_q == ADDR_W'(MAX_ROW_BYTES - 1));
  assign sts_o.emit_idle = (phase_q == PH_IDLE);

  assign out_byte_o     = out_byte_q;
  assign out_valid_o    = out_valid_q;
  assign end_of_burst_o = eob_q;
  assign overrun_o      = ovr_out_q;

endmodule

`default_nettype wire

// File: rtl/dot_matrix_band_transposer_unit.sv
// ----------------------------------------------------------------------------
// dot_matrix_band_transposer_unit
// gathers raster rows into a dot band and streams print-head column commands
//
//   channel  handshake                  payload
//   req      req_valid_i / req_stall_o  req_type_i, pixel_byte_i, row_end_i
//   res      res_valid_o / res_stall_i  out_byte_o, out_valid_o,
//                                       end_of_burst_o, overrun_o
//   cfg      apb write/read             row_bytes at byte address 0
//
// raster byte: bank read, then write-back to the banks of set pixels
// pull: issue, then commit; the result lands in the output register at the commit
// form feed, dropped item or unused code: handled in the idle state, no further step
// after reset a clearing pass zeroes every address of the band store;
//   req_stall_o stays high meanwhile
// req_stall_o is also high while a result waits and res_stall_i is high
// ----------------------------------------------------------------------------
`default_nettype none

module dot_matrix_band_transposer_unit #(
  parameter int unsigned MAX_ROW_BYTES = 512,
  parameter int unsigned BAND_ROWS     = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [7:0]                    pixel_byte_i,
  input  logic                          row_end_i,
  output logic                          res_valid_o,
  input  logic                          res_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          out_valid_o,
  output logic                          end_of_burst_o,
  output logic                          overrun_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmbt_pkg::APB_AW-1:0]   paddr,
  input  logic [dmbt_pkg::APB_DW-1:0]   pwdata,
  output logic [dmbt_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import dmbt_pkg::*;

  logic [RB_W-1:0] row_bytes_q;
  logic            reg_hit;
  cmd_t            cmd;
  sts_t            sts;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_ROW_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= RB_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      row_bytes_q <= pwdata[RB_W-1:0];
    end
  end

  assign prdata = reg_hit ? APB_DW'(row_bytes_q) : '0;

  dmbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_type_i  (req_e'(req_type_i)),
    .req_stall_o (req_stall_o),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dmbt_dpath #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .BAND_ROWS     (BAND_ROWS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pixel_byte_i   (pixel_byte_i),
    .row_end_i      (row_end_i),
    .row_bytes_i    (row_bytes_q),
    .out_byte_o     (out_byte_o),
    .out_valid_o    (out_valid_o),
    .end_of_burst_o (end_of_burst_o),
    .overrun_o      (overrun_o)
  );

endmodule

`default_nettype wire

// File: rtl/dmbt_checker.sv
// ----------------------------------------------------------------------------
// dmbt_checker
// port-level checks for the band transposer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "dot_matrix_band_transposer_unit_assert.svh"

module dmbt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_stall_o,
  input logic [1:0] req_type_i,
  input logic       res_valid_o,
  input logic       res_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_valid_o,
  input logic       end_of_burst_o,
  input logic       overrun_o
);
  import dmbt_pkg::*;

  logic pull_acc;
  logic res_held;

  assign pull_acc = req_valid_i && !req_stall_o && (req_type_i == REQ_PULL);
  assign res_held = res_valid_o && res_stall_i;

  `DMBT_ASSERT_NEXT(a_res_hold, res_held, res_valid_o, "result dropped while stalled")

  `DMBT_ASSERT(a_idle_pull, res_valid_o && !out_valid_o,
    (out_byte_o == 8'h00) && !end_of_burst_o, "empty pull carries data")

  `DMBT_ASSERT(a_new_from_pull, res_valid_o && !$past(res_held),
    $past(pull_acc, 2), "item without a pull")

  `DMBT_ASSERT(a_overrun_sticky, res_valid_o && $past(res_valid_o && overrun_o),
    overrun_o, "overrun flag cleared")

endmodule

bind dot_matrix_band_transposer_unit dmbt_checker u_dmbt_checker (.*);

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - dot matrix band transposer unit
// drives raster bytes, form feeds and output pulls through the valid/stall
// request channel, tracks band contents and the command stream in a local
// model, and compares every pulled byte field by field; row_bytes is set over
// the apb port between phases, under several idle and stall mixes
// ----------------------------------------------------------------------------

module tb;
  import dmbt_pkg::*;

  localparam int unsigned ROW_LIMIT     = 512;
  localparam int unsigned BAND_DEPTH    = 48;
  localparam int unsigned SLOTS_PER_COL = 6;
  localparam int unsigned STORE_BYTES   = ROW_LIMIT * 8 * SLOTS_PER_COL;
  localparam int unsigned HEAD_BYTES    = 5;
  localparam int unsigned QUIET_CYCLES  = 8;

  localparam bit [7:0]  B_ESC    = 8'h1B;
  localparam bit [7:0]  B_STAR   = 8'h2A;
  localparam bit [7:0]  B_H      = 8'h48;
  localparam bit [7:0]  B_CR     = 8'h0D;
  localparam bit [7:0]  B_FF     = 8'h0C;
  localparam bit [31:0] TAIL_SEQ = 32'h1B2B300A;

  localparam logic [APB_AW-1:0] ROW_BYTES_ADDR = APB_AW'(4 * REG_ROW_BYTES);

  typedef enum bit [2:0] {ST_IDLE, ST_HEAD, ST_DATA, ST_CR, ST_TAIL, ST_FF} stream_e;

  typedef struct packed {
    bit [7:0] data;
    bit       valid;
    bit       eob;
    bit       ovr;
  } cmd_byte_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              req_valid_i  = 1'b0;
  logic              req_stall_o;
  logic [1:0]        req_type_i   = REQ_NONE;
  logic [7:0]        pixel_byte_i = 8'h00;
  logic              row_end_i    = 1'b0;
  logic              res_valid_o;
  logic              res_stall_i  = 1'b0;
  logic [7:0]        out_byte_o;
  logic              out_valid_o;
  logic              end_of_burst_o;
  logic              overrun_o;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [APB_AW-1:0] paddr        = '0;
  logic [APB_DW-1:0] pwdata       = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // model state
  bit [9:0]    cfg_row_bytes = 10'd512;
  bit [7:0]    band_mem [STORE_BYTES];
  int unsigned row_idx      = 0;
  int unsigned byte_pos     = 0;
  int unsigned used_cols    = 0;
  stream_e     stream_phase = ST_IDLE;
  int unsigned stream_pos   = 0;
  bit          ff_owed      = 1'b0;
  bit          drop_seen    = 1'b0;

  cmd_byte_t   expected_bytes [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned useful_items  = 0;
  int unsigned bytes_checked = 0;
  int unsigned bands_opened  = 0;
  int unsigned fails         = 0;

  dot_matrix_band_transposer_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_i),
    .req_stall_o    (req_stall_o),
    .req_type_i     (req_type_i),
    .pixel_byte_i   (pixel_byte_i),
    .row_end_i      (row_end_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .out_byte_o     (out_byte_o),
    .out_valid_o    (out_valid_o),
    .end_of_burst_o (end_of_burst_o),
    .overrun_o      (overrun_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #25_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic void open_band();
    stream_pos   = 0;
    stream_phase = (used_cols != 0) ? ST_HEAD : ST_TAIL;
    row_idx      = 0;
    byte_pos     = 0;
    bands_opened++;
  endfunction

  function automatic void store_raster(bit [7:0] pix, bit last);
    int unsigned lim;
    int unsigned col;
    int unsigned at;
    lim = (cfg_row_bytes < ROW_LIMIT) ? cfg_row_bytes : ROW_LIMIT;
    if (byte_pos < lim) begin
      for (int j = 0; j < 8; j++) begin
        if (pix[7-j]) begin
          col = byte_pos * 8 + j;
          at  = col * SLOTS_PER_COL + row_idx / 8;
          band_mem[at][7 - row_idx % 8] = 1'b1;
          if (col + 1 > used_cols) used_cols = col + 1;
        end
      end
      byte_pos++;
    end
    if (last) begin
      byte_pos = 0;
      row_idx++;
      if (row_idx >= BAND_DEPTH) begin
        ff_owed = 1'b0;
        open_band();
      end
    end
  endfunction

  function automatic void queue_form_feed();
    ff_owed = 1'b1;
    if (row_idx != 0 || byte_pos != 0) begin
      open_band();
    end else begin
      stream_phase = ST_FF;
      stream_pos   = 0;
    end
  endfunction

  function automatic cmd_byte_t next_command_byte();
    cmd_byte_t r;
    r       = '0;
    r.valid = 1'b1;
    case (stream_phase)
      ST_HEAD: begin
        case (stream_pos)
          0:       r.data = B_ESC;
          1:       r.data = B_STAR;
          2:       r.data = B_H;
          3:       r.data = 8'(used_cols);
          default: r.data = 8'(used_cols >> 8);
        endcase
        stream_pos++;
        if (stream_pos >= HEAD_BYTES) begin
          stream_pos   = 0;
          stream_phase = ST_DATA;
        end
      end
      ST_DATA: begin
        r.data               = band_mem[stream_pos];
        band_mem[stream_pos] = 8'h00;
        stream_pos++;
        if (stream_pos >= used_cols * SLOTS_PER_COL) begin
          stream_pos   = 0;
          stream_phase = ST_CR;
        end
      end
      ST_CR: begin
        r.data       = B_CR;
        stream_pos   = 0;
        stream_phase = ST_TAIL;
      end
      ST_TAIL: begin
        r.data = TAIL_SEQ[31 - 8 * (stream_pos % 4) -: 8];
        stream_pos++;
        if (stream_pos >= 4) begin
          stream_pos = 0;
          used_cols  = 0;
          if (ff_owed) begin
            stream_phase = ST_FF;
          end else begin
            stream_phase = ST_IDLE;
            r.eob        = 1'b1;
          end
        end
      end
      ST_FF: begin
        r.data       = B_FF;
        r.eob        = 1'b1;
        ff_owed      = 1'b0;
        stream_pos   = 0;
        stream_phase = ST_IDLE;
      end
      default: r.valid = 1'b0;
    endcase
    r.ovr = drop_seen;
    return r;
  endfunction

  function automatic void apply_item(req_e kind, bit [7:0] pix, bit last);
    items_sent++;
    case (kind)
      REQ_PULL: begin
        expected_bytes.push_back(next_command_byte());
        useful_items++;
      end
      REQ_NONE: ;
      default: begin
        if (stream_phase != ST_IDLE) begin
          drop_seen = 1'b1;
        end else begin
          useful_items++;
          if (kind == REQ_RASTER) store_raster(pix, last);
          else queue_form_feed();
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_pixels();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'h01 << $urandom_range(7);
      2:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(req_e kind, logic [7:0] pix, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i  <= 1'b1;
    req_type_i   <= kind;
    pixel_byte_i <= pix;
    row_end_i    <= last;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    apply_item(kind, pix, last);
  endtask

  task automatic wait_quiet();
    req_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_row_bytes(logic [9:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROW_BYTES_ADDR;
    pwdata  <= APB_DW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cfg_row_bytes = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[RB_W-1:0] !== v) begin
      $error("row_bytes readback: expected %0d, actual %0d", v, prdata[RB_W-1:0]);
      fails++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_stream(bit noisy);
    while (stream_phase != ST_IDLE) begin
      if (noisy && $urandom_range(19) == 0)
        send_item(req_e'($urandom_range(3)), 8'($urandom), 1'($urandom));
      else
        send_item(REQ_PULL, 8'($urandom), 1'($urandom));
    end
    if (noisy && $urandom_range(9) == 0) send_item(REQ_PULL, 8'($urandom), 1'($urandom));
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    cmd_byte_t want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $error("result with nothing expected: out_byte 0x%0h", out_byte_o);
        fails++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        check_field("out_byte", want.data, out_byte_o);
        check_field("out_valid", want.valid, out_valid_o);
        check_field("end_of_burst", want.eob, end_of_burst_o);
        check_field("overrun", want.ovr, overrun_o);
      end
    end
    res_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);
  end

  task automatic test_sparse_rows();
    wait_quiet();
    set_row_bytes(10'(ROW_LIMIT));
    send_item(REQ_RASTER, 8'h80, 1'b1);
    send_item(REQ_RASTER, 8'h00, 1'b0);
    send_item(REQ_RASTER, 8'h01, 1'b1);
    send_item(REQ_FF, 8'hFF, 1'b1);
    drain_stream(1'b0);
    send_item(REQ_PULL, 8'h00, 1'b0);
  endtask

  task automatic test_empty_form_feed();
    send_item(REQ_FF, 8'h00, 1'b0);
    drain_stream(1'b0);
    send_item(REQ_PULL, 8'hFF, 1'b1);
  endtask

  task automatic test_open_row_at_form_feed();
    send_item(REQ_RASTER, 8'hA5, 1'b0);
    send_item(REQ_FF, 8'h5A, 1'b0);
    drain_stream(1'b0);
  endtask

  task automatic test_zero_row_bytes();
    wait_quiet();
    set_row_bytes(10'd0);
    send_item(REQ_RASTER, 8'hFF, 1'b0);
    send_item(REQ_RASTER, 8'hAA, 1'b1);
    send_item(REQ_FF, 8'h00, 1'b0);
    drain_stream(1'b0);
  endtask

  task automatic test_unused_code();
    send_item(REQ_NONE, 8'hFF, 1'b1);
    send_item(REQ_NONE, 8'h00, 1'b0);
    send_item(REQ_PULL, 8'h3C, 1'b0);
  endtask

  task automatic test_full_band();
    wait_quiet();
    set_row_bytes(10'd1);
    for (int r = 0; r < BAND_DEPTH; r++) begin
      send_item(REQ_RASTER, (r == BAND_DEPTH - 1) ? 8'h01 : rand_pixels(), 1'b0);
      send_item(REQ_RASTER, 8'hFF, 1'b1);
    end
    drain_stream(1'b0);
  endtask

  task automatic test_widest_row();
    logic [7:0] pix;
    wait_quiet();
    set_row_bytes(10'h3FF);
    for (int b = 0; b < ROW_LIMIT + 2; b++) begin
      if (b == 0) pix = 8'h01;
      else if (b >= ROW_LIMIT) pix = 8'hFF;
      else pix = (b < 4 && $urandom_range(1) == 0) ? 8'($urandom) : 8'h00;
      send_item(REQ_RASTER, pix, b == ROW_LIMIT + 1);
    end
    send_item(REQ_RASTER, 8'h80, 1'b1);
    send_item(REQ_FF, 8'h00, 1'b0);
    drain_stream(1'b0);
  endtask

  task automatic test_overrun();
    send_item(REQ_FF, 8'h00, 1'b0);
    send_item(REQ_RASTER, 8'hFF, 1'b1);
    send_item(REQ_FF, 8'h00, 1'b0);
    send_item(REQ_NONE, 8'h00, 1'b0);
    drain_stream(1'b0);
  endtask

  task automatic test_random_traffic(int unsigned target, logic [9:0] rb);
    int unsigned stop_at;
    int unsigned rows;
    int unsigned nbytes;
    bit          keep_open;
    wait_quiet();
    set_row_bytes(rb);
    stop_at = useful_items + target;
    while (useful_items < stop_at) begin
      if ($urandom_range(99) < 80) begin
        rows = ($urandom_range(1) != 0) ? BAND_DEPTH : $urandom_range(1, BAND_DEPTH - 1);
        for (int r = 0; r < rows; r++) begin
          nbytes    = $urandom_range(1, rb + 1);
          keep_open = (r == rows - 1) && (rows < BAND_DEPTH) && ($urandom_range(9) == 0);
          for (int b = 0; b < nbytes; b++)
            send_item(REQ_RASTER, rand_pixels(), (b == nbytes - 1) && !keep_open);
        end
        if (rows < BAND_DEPTH) send_item(REQ_FF, 8'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(req_e'($urandom_range(3)), rand_pixels(), 1'($urandom));
      end
      drain_stream(1'b1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 50;
    test_sparse_rows();
    test_empty_form_feed();
    test_open_row_at_form_feed();
    test_zero_row_bytes();
    test_unused_code();
    test_full_band();
    test_widest_row();
    test_overrun();
    test_random_traffic(80, 10'd2);

    send_idle_pct = 50;
    recv_idle_pct = 34;
    test_random_traffic(80, 10'd1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(80, 10'd4);

    wait_quiet();
    $display("sent %0d items, %0d took effect; %0d command bytes compared over %0d bands",
             items_sent, useful_items, bytes_checked, bands_opened);
    $display("row_bytes settings 0, 1, 2, 4, 512 and 1023 under three idle mixes");
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
